@@ rtl/i2cmbc_pkg.sv @@
package i2cmbc_pkg;

    localparam int HOLD_WIDTH    = 16;
    localparam int TIMEOUT_WIDTH = 16;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_RESTART = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_WRITE   = 3'd4;
    localparam logic [2:0] CMD_READ    = 3'd5;

    localparam logic [1:0] REG_HALF    = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_STRETCH = 2'd2;

    // one tick as it travels from front to back
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       scl_in;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       ack_received;
        logic [7:0] read_data;
        logic       timed_out;
    } res_t;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [15:0] stretch_timeout_ticks;
        logic        stretch_check_enable;
    } cfg_t;

endpackage

@@ rtl/i2c_master_byte_controller.sv @@
// path: a tick is held in the queue, then its result is registered in the output register
// throughput: one tick per cycle while the result channel is ready; the phase sequencer advances once per accepted tick
// reset: synchronous active-low aresetn returns the sequencer to idle with both lines
// released, empties the queue and restores the registers to their defaults
module i2c_master_byte_controller
    import i2cmbc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[2:0], write_byte[10:3], send_ack[11], scl_in[12], sda_in[13], zero[15:14]
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // scl_out[0], sda_out[1], busy_res[2], done_res[3], ack_received[4],
    // read_data[12:5], timed_out[13], zero[15:14]
    output logic [15:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    cfg_t  cfg_reg;
    tick_t s_tick, q_tick;
    res_t  res;
    logic  q_valid, q_ready;
    logic  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period_ticks     <= 16'd5;
            cfg_reg.stretch_timeout_ticks <= 16'd1000;
            cfg_reg.stretch_check_enable  <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_HALF:    cfg_reg.half_period_ticks     <= pwdata[15:0];
                REG_TIMEOUT: cfg_reg.stretch_timeout_ticks <= pwdata[15:0];
                REG_STRETCH: cfg_reg.stretch_check_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HALF:    prdata = {16'd0, cfg_reg.half_period_ticks};
            REG_TIMEOUT: prdata = {16'd0, cfg_reg.stretch_timeout_ticks};
            REG_STRETCH: prdata = {31'd0, cfg_reg.stretch_check_enable};
            default:     prdata = 32'd0;
        endcase
    end

    assign s_tick.cmd        = s_tdata[2:0];
    assign s_tick.write_byte = s_tdata[10:3];
    assign s_tick.send_ack   = s_tdata[11];
    assign s_tick.scl_in     = s_tdata[12];
    assign s_tick.sda_in     = s_tdata[13];

    i2cmbc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tick),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_tick)
    );

    i2cmbc_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_tick),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {2'b00, res.timed_out, res.read_data, res.ack_received,
                      res.done_res, res.busy_res, res.sda_out, res.scl_out};
endmodule

@@ rtl/i2cmbc_fifo.sv @@
module i2cmbc_fifo
    import i2cmbc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  tick_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output tick_t out_data
);
    // two-entry queue between the input channel and the engine
    tick_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ rtl/i2cmbc_engine.sv @@
module i2cmbc_engine
    import i2cmbc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  tick_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_data
);
    localparam logic [4:0] PH_IDLE       = 5'd0;
    localparam logic [4:0] PH_ST_SDA_LO  = 5'd1;
    localparam logic [4:0] PH_ST_SCL_LO  = 5'd2;
    localparam logic [4:0] PH_RS_BOTH_HI = 5'd3;
    localparam logic [4:0] PH_RS_SDA_LO  = 5'd4;
    localparam logic [4:0] PH_RS_SCL_LO  = 5'd5;
    localparam logic [4:0] PH_SP_SDA_LO  = 5'd6;
    localparam logic [4:0] PH_SP_SCL_HI  = 5'd7;
    localparam logic [4:0] PH_SP_SDA_HI  = 5'd8;
    localparam logic [4:0] PH_WR_BIT     = 5'd9;
    localparam logic [4:0] PH_WR_SCL_HI  = 5'd10;
    localparam logic [4:0] PH_WR_SCL_LO  = 5'd11;
    localparam logic [4:0] PH_WR_ACK_REL = 5'd12;
    localparam logic [4:0] PH_WR_ACK_HI  = 5'd13;
    localparam logic [4:0] PH_WR_ACK_LO  = 5'd14;
    localparam logic [4:0] PH_ABORT_REL  = 5'd15;
    localparam logic [4:0] PH_RD_REL     = 5'd16;
    localparam logic [4:0] PH_RD_SCL_HI  = 5'd17;
    localparam logic [4:0] PH_RD_SCL_LO  = 5'd18;
    localparam logic [4:0] PH_RD_ACK_DRV = 5'd19;
    localparam logic [4:0] PH_RD_ACK_HI  = 5'd20;
    localparam logic [4:0] PH_RD_ACK_LO  = 5'd21;
    localparam logic [4:0] PH_RD_ACK_REL = 5'd22;

    logic [4:0]               phase_reg, phase_next;
    logic [3:0]               bit_index_reg, bit_index_next;
    logic [HOLD_WIDTH-1:0]    hold_count_reg, hold_count_next;
    logic [TIMEOUT_WIDTH-1:0] stretch_count_reg, stretch_count_next;
    logic [7:0]               shift_reg, shift_next;
    logic                     scl_drive_reg, scl_drive_next;
    logic                     sda_drive_reg, sda_drive_next;
    logic                     ack_latch_reg, ack_latch_next;
    logic                     ack_to_send_reg, ack_to_send_next;
    logic [7:0]               read_byte_reg, read_byte_next;
    logic                     fault_reg, fault_next;
    logic                     done_now;
    logic                     out_valid_reg;
    res_t                     out_data_reg;
    logic                     step;
    logic [HOLD_WIDTH-1:0]    hold_load;
    logic                     is_str;
    logic [4:0]               tgt;
    logic                     go;
    logic                     go_finish;

    // output register; a new tick is taken while the register is empty or as the held result leaves
    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign hold_load = (cfg.half_period_ticks[HOLD_WIDTH-1:0] == '0) ?
                       HOLD_WIDTH'(1) : cfg.half_period_ticks[HOLD_WIDTH-1:0];
    assign is_str = (phase_reg == PH_SP_SCL_HI) || (phase_reg == PH_WR_SCL_HI) ||
                    (phase_reg == PH_WR_ACK_HI) || (phase_reg == PH_RD_SCL_HI) ||
                    (phase_reg == PH_RD_ACK_HI);

    always_comb begin
        phase_next         = phase_reg;
        bit_index_next     = bit_index_reg;
        hold_count_next    = hold_count_reg;
        stretch_count_next = stretch_count_reg;
        shift_next         = shift_reg;
        ack_latch_next     = ack_latch_reg;
        ack_to_send_next   = ack_to_send_reg;
        read_byte_next     = read_byte_reg;
        fault_next         = fault_reg;
        done_now           = 1'b0;
        tgt                = PH_IDLE;
        go                 = 1'b0;
        go_finish          = 1'b0;

        if (phase_reg == PH_IDLE) begin
            go = 1'b1;
            case (in_data.cmd)
                CMD_START:   tgt = PH_ST_SDA_LO;
                CMD_RESTART: tgt = PH_RS_BOTH_HI;
                CMD_STOP:    tgt = PH_SP_SDA_LO;
                CMD_WRITE: begin
                    tgt            = PH_WR_BIT;
                    shift_next     = in_data.write_byte;
                    bit_index_next = 4'd7;
                end
                CMD_READ: begin
                    tgt              = PH_RD_REL;
                    ack_to_send_next = in_data.send_ack;
                    shift_next       = 8'd0;
                    bit_index_next   = 4'd0;
                end
                default: go = 1'b0;
            endcase
            if (go) fault_next = 1'b0;
        end else begin
            if (is_str && stretch_count_reg != '1) begin
                stretch_count_next = stretch_count_reg + 1'b1;
            end
            if (hold_count_reg > HOLD_WIDTH'(1)) begin
                hold_count_next = hold_count_reg - 1'b1;
            end else begin
                hold_count_next = '0;
                if (is_str && cfg.stretch_check_enable && !in_data.scl_in) begin
                    if (32'(stretch_count_next) >= 32'(cfg.stretch_timeout_ticks)) begin
                        fault_next = 1'b1;
                        case (phase_reg)
                            PH_SP_SCL_HI: begin
                                go = 1'b1; tgt = PH_SP_SDA_HI;
                            end
                            PH_WR_SCL_HI: begin
                                ack_latch_next = 1'b0; go = 1'b1; tgt = PH_ABORT_REL;
                            end
                            PH_WR_ACK_HI: begin
                                ack_latch_next = 1'b0; go_finish = 1'b1;
                            end
                            PH_RD_ACK_HI: begin
                                go = 1'b1; tgt = PH_ABORT_REL;
                            end
                            default: go_finish = 1'b1;
                        endcase
                    end
                end else begin
                    go = 1'b1;
                    case (phase_reg)
                        PH_ST_SDA_LO:  tgt = PH_ST_SCL_LO;
                        PH_RS_BOTH_HI: tgt = PH_RS_SDA_LO;
                        PH_RS_SDA_LO:  tgt = PH_RS_SCL_LO;
                        PH_SP_SDA_LO:  tgt = PH_SP_SCL_HI;
                        PH_SP_SCL_HI:  tgt = PH_SP_SDA_HI;
                        PH_WR_BIT:     tgt = PH_WR_SCL_HI;
                        PH_WR_SCL_HI:  tgt = PH_WR_SCL_LO;
                        PH_WR_SCL_LO: begin
                            if (bit_index_reg == 4'd0) begin
                                tgt = PH_WR_ACK_REL;
                            end else begin
                                bit_index_next = bit_index_reg - 1'b1;
                                tgt = PH_WR_BIT;
                            end
                        end
                        PH_WR_ACK_REL: tgt = PH_WR_ACK_HI;
                        PH_WR_ACK_HI: begin
                            ack_latch_next = !in_data.sda_in;
                            tgt = PH_WR_ACK_LO;
                        end
                        PH_RD_REL:     tgt = PH_RD_SCL_HI;
                        PH_RD_SCL_HI: begin
                            shift_next     = {shift_reg[6:0], in_data.sda_in};
                            bit_index_next = bit_index_reg + 1'b1;
                            if (bit_index_next >= 4'd8) read_byte_next = shift_next;
                            tgt = PH_RD_SCL_LO;
                        end
                        PH_RD_SCL_LO:
                            tgt = (bit_index_reg < 4'd8) ? PH_RD_SCL_HI : PH_RD_ACK_DRV;
                        PH_RD_ACK_DRV: tgt = PH_RD_ACK_HI;
                        PH_RD_ACK_HI:  tgt = PH_RD_ACK_LO;
                        PH_RD_ACK_LO:  tgt = PH_RD_ACK_REL;
                        default: begin
                            go = 1'b0; go_finish = 1'b1;
                        end
                    endcase
                end
            end
        end

        scl_drive_next = scl_drive_reg;
        sda_drive_next = sda_drive_reg;
        if (go_finish) begin
            phase_next      = PH_IDLE;
            hold_count_next = '0;
            done_now        = 1'b1;
        end else if (go) begin
            phase_next      = tgt;
            hold_count_next = hold_load;
            if (tgt == PH_SP_SCL_HI || tgt == PH_WR_SCL_HI || tgt == PH_WR_ACK_HI ||
                tgt == PH_RD_SCL_HI || tgt == PH_RD_ACK_HI) begin
                stretch_count_next = '0;
                scl_drive_next     = 1'b1;
            end
            case (tgt)
                PH_ST_SDA_LO, PH_RS_SDA_LO, PH_SP_SDA_LO: sda_drive_next = 1'b0;
                PH_ST_SCL_LO, PH_RS_SCL_LO, PH_WR_SCL_LO, PH_WR_ACK_LO,
                PH_RD_SCL_LO, PH_RD_ACK_LO: scl_drive_next = 1'b0;
                PH_RS_BOTH_HI: begin
                    sda_drive_next = 1'b1; scl_drive_next = 1'b1;
                end
                PH_SP_SDA_HI, PH_WR_ACK_REL, PH_ABORT_REL, PH_RD_REL,
                PH_RD_ACK_REL: sda_drive_next = 1'b1;
                PH_WR_BIT:     sda_drive_next = shift_next[bit_index_next[2:0]];
                PH_RD_ACK_DRV: sda_drive_next = !ack_to_send_next;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            bit_index_reg     <= 4'd0;
            hold_count_reg    <= '0;
            stretch_count_reg <= '0;
            shift_reg         <= 8'd0;
            scl_drive_reg     <= 1'b1;
            sda_drive_reg     <= 1'b1;
            ack_latch_reg     <= 1'b0;
            ack_to_send_reg   <= 1'b0;
            read_byte_reg     <= 8'd0;
            fault_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (step) begin
                phase_reg         <= phase_next;
                bit_index_reg     <= bit_index_next;
                hold_count_reg    <= hold_count_next;
                stretch_count_reg <= stretch_count_next;
                shift_reg         <= shift_next;
                scl_drive_reg     <= scl_drive_next;
                sda_drive_reg     <= sda_drive_next;
                ack_latch_reg     <= ack_latch_next;
                ack_to_send_reg   <= ack_to_send_next;
                read_byte_reg     <= read_byte_next;
                fault_reg         <= fault_next;
                out_valid_reg     <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg.scl_out      <= scl_drive_next;
            out_data_reg.sda_out      <= sda_drive_next;
            out_data_reg.busy_res     <= (phase_next != PH_IDLE);
            out_data_reg.done_res     <= done_now;
            out_data_reg.ack_received <= ack_latch_next;
            out_data_reg.read_data    <= read_byte_next;
            out_data_reg.timed_out    <= done_now && fault_next;
        end
    end
endmodule

@@ verif/tb_i2c_master_byte_controller.sv @@
module tb_i2c_master_byte_controller;
    import i2cmbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [4:0] {
        P_IDLE, P_ST_SDA_LO, P_ST_SCL_LO, P_RS_BOTH_HI, P_RS_SDA_LO, P_RS_SCL_LO,
        P_SP_SDA_LO, P_SP_SCL_HI, P_SP_SDA_HI, P_WR_BIT, P_WR_SCL_HI, P_WR_SCL_LO,
        P_WR_ACK_REL, P_WR_ACK_HI, P_WR_ACK_LO, P_ABORT_REL, P_RD_REL, P_RD_SCL_HI,
        P_RD_SCL_LO, P_RD_ACK_DRV, P_RD_ACK_HI, P_RD_ACK_LO, P_RD_ACK_REL
    } bus_phase_e;

    localparam int MODE_NONE = 0, MODE_SEND = 1, MODE_RECV = 2, MODE_BOTH = 3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    i2c_master_byte_controller DUT (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // line engine shadow state and registers
    bus_phase_e  eng_phase = P_IDLE;
    logic [3:0]  eng_bit = '0;
    logic [15:0] eng_hold = '0;
    logic [15:0] eng_stretch = '0;
    logic [7:0]  eng_shift = '0;
    logic [7:0]  eng_rbyte = '0;
    logic        eng_scl = 1'b1, eng_sda = 1'b1;
    logic        eng_ack = 1'b0, eng_ack_send = 1'b0, eng_fault = 1'b0, eng_done = 1'b0;
    logic [15:0] cfg_half = 16'd5, cfg_tmo = 16'd1000;
    logic        cfg_en = 1'b1;

    tick_t tick_q[$];
    res_t  bus_result_q[$];
    int    mismatches = 0;
    int    results_seen = 0, timeouts_seen = 0, cmds_started = 0;
    int    idle_mode = MODE_NONE;
    bit    gen_done = 1'b0;

    function automatic bit is_stretch(bus_phase_e p);
        return p inside {P_SP_SCL_HI, P_WR_SCL_HI, P_WR_ACK_HI, P_RD_SCL_HI, P_RD_ACK_HI};
    endfunction

    task automatic enter_phase(bus_phase_e p);
        eng_phase = p;
        eng_hold = (cfg_half == 0) ? 16'd1 : cfg_half;
        if (is_stretch(p)) eng_stretch = '0;
        case (p)
            P_ST_SDA_LO, P_RS_SDA_LO, P_SP_SDA_LO: eng_sda = 1'b0;
            P_ST_SCL_LO, P_RS_SCL_LO, P_WR_SCL_LO, P_WR_ACK_LO, P_RD_SCL_LO,
            P_RD_ACK_LO: eng_scl = 1'b0;
            P_RS_BOTH_HI: begin
                eng_sda = 1'b1;
                eng_scl = 1'b1;
            end
            P_SP_SCL_HI, P_WR_SCL_HI, P_WR_ACK_HI, P_RD_SCL_HI, P_RD_ACK_HI: eng_scl = 1'b1;
            P_SP_SDA_HI, P_WR_ACK_REL, P_ABORT_REL, P_RD_REL, P_RD_ACK_REL: eng_sda = 1'b1;
            P_WR_BIT: eng_sda = eng_shift[eng_bit[2:0]];
            P_RD_ACK_DRV: eng_sda = !eng_ack_send;
            default: ;
        endcase
    endtask

    task automatic finish_cmd();
        eng_phase = P_IDLE;
        eng_hold = '0;
        eng_done = 1'b1;
    endtask

    task automatic next_phase(logic sda);
        case (eng_phase)
            P_ST_SDA_LO: enter_phase(P_ST_SCL_LO);
            P_RS_BOTH_HI: enter_phase(P_RS_SDA_LO);
            P_RS_SDA_LO: enter_phase(P_RS_SCL_LO);
            P_SP_SDA_LO: enter_phase(P_SP_SCL_HI);
            P_SP_SCL_HI: enter_phase(P_SP_SDA_HI);
            P_WR_BIT: enter_phase(P_WR_SCL_HI);
            P_WR_SCL_HI: enter_phase(P_WR_SCL_LO);
            P_WR_SCL_LO: begin
                if (eng_bit == 0) begin
                    enter_phase(P_WR_ACK_REL);
                end else begin
                    eng_bit = eng_bit - 4'd1;
                    enter_phase(P_WR_BIT);
                end
            end
            P_WR_ACK_REL: enter_phase(P_WR_ACK_HI);
            P_WR_ACK_HI: begin
                eng_ack = !sda;
                enter_phase(P_WR_ACK_LO);
            end
            P_RD_REL: enter_phase(P_RD_SCL_HI);
            P_RD_SCL_HI: begin
                eng_shift = {eng_shift[6:0], sda};
                eng_bit = eng_bit + 4'd1;
                if (eng_bit >= 8) eng_rbyte = eng_shift;
                enter_phase(P_RD_SCL_LO);
            end
            P_RD_SCL_LO: begin
                if (eng_bit < 8) enter_phase(P_RD_SCL_HI);
                else enter_phase(P_RD_ACK_DRV);
            end
            P_RD_ACK_DRV: enter_phase(P_RD_ACK_HI);
            P_RD_ACK_HI: enter_phase(P_RD_ACK_LO);
            P_RD_ACK_LO: enter_phase(P_RD_ACK_REL);
            default: finish_cmd();
        endcase
    endtask

    task automatic stretch_abort();
        eng_fault = 1'b1;
        case (eng_phase)
            P_SP_SCL_HI: enter_phase(P_SP_SDA_HI);
            P_WR_SCL_HI: begin
                eng_ack = 1'b0;
                enter_phase(P_ABORT_REL);
            end
            P_WR_ACK_HI: begin
                eng_ack = 1'b0;
                finish_cmd();
            end
            P_RD_ACK_HI: enter_phase(P_ABORT_REL);
            default: finish_cmd();
        endcase
    endtask

    task automatic predict_bus(tick_t t);
        res_t r;
        bit   str;
        eng_done = 1'b0;
        if (eng_phase == P_IDLE) begin
            if (t.cmd inside {CMD_START, CMD_RESTART, CMD_STOP, CMD_WRITE, CMD_READ}) begin
                cmds_started++;
                eng_fault = 1'b0;
                case (t.cmd)
                    CMD_START: enter_phase(P_ST_SDA_LO);
                    CMD_RESTART: enter_phase(P_RS_BOTH_HI);
                    CMD_STOP: enter_phase(P_SP_SDA_LO);
                    CMD_WRITE: begin
                        eng_shift = t.write_byte;
                        eng_bit = 4'd7;
                        enter_phase(P_WR_BIT);
                    end
                    default: begin
                        eng_ack_send = t.send_ack;
                        eng_shift = '0;
                        eng_bit = '0;
                        enter_phase(P_RD_REL);
                    end
                endcase
            end
        end else begin
            str = is_stretch(eng_phase);
            if (str && eng_stretch != 16'hffff) eng_stretch++;
            if (eng_hold > 1) begin
                eng_hold--;
            end else begin
                eng_hold = '0;
                if (str && cfg_en && !t.scl_in) begin
                    if (eng_stretch >= cfg_tmo) stretch_abort();
                end else begin
                    next_phase(t.sda_in);
                end
            end
        end
        r.scl_out = eng_scl;
        r.sda_out = eng_sda;
        r.busy_res = (eng_phase != P_IDLE);
        r.done_res = eng_done;
        r.ack_received = eng_ack;
        r.read_data = eng_rbyte;
        r.timed_out = eng_done && eng_fault;
        bus_result_q.push_back(r);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // input acceptance and result checking
    always @(posedge aclk) begin
        tick_t t;
        res_t  e;
        if (aresetn && s_tvalid && s_tready) begin
            t.cmd = s_tdata[2:0];
            t.write_byte = s_tdata[10:3];
            t.send_ack = s_tdata[11];
            t.scl_in = s_tdata[12];
            t.sda_in = s_tdata[13];
            predict_bus(t);
        end
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (bus_result_q.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                e = bus_result_q.pop_front();
                if (m_tdata[0] != e.scl_out) report_mismatch("scl_out", m_tdata[0], e.scl_out);
                if (m_tdata[1] != e.sda_out) report_mismatch("sda_out", m_tdata[1], e.sda_out);
                if (m_tdata[2] != e.busy_res) report_mismatch("busy", m_tdata[2], e.busy_res);
                if (m_tdata[3] != e.done_res) report_mismatch("done", m_tdata[3], e.done_res);
                if (m_tdata[4] != e.ack_received)
                    report_mismatch("ack_received", m_tdata[4], e.ack_received);
                if (m_tdata[12:5] != e.read_data)
                    report_mismatch("read_data", m_tdata[12:5], e.read_data);
                if (m_tdata[13] != e.timed_out)
                    report_mismatch("timed_out", m_tdata[13], e.timed_out);
                if (e.timed_out) timeouts_seen++;
            end
        end
    end

    // tick driver and result backpressure
    always @(negedge aclk) begin
        bit   idle_now;
        tick_t t;
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                idle_now = (idle_mode == MODE_SEND) ? ($urandom_range(0, 99) < 55) :
                           (idle_mode == MODE_BOTH) ? ($urandom_range(0, 99) < 11) : 1'b0;
                if (tick_q.size() != 0 && !idle_now) begin
                    t = tick_q.pop_front();
                    s_tdata <= {2'b00, t.sda_in, t.scl_in, t.send_ack, t.write_byte, t.cmd};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= (idle_mode == MODE_RECV) ? ($urandom_range(0, 99) >= 55) :
                        (idle_mode == MODE_BOTH) ? ($urandom_range(0, 99) >= 11) : 1'b1;
        end
    end

    int low_run = 0;

    task automatic push_tick(logic [2:0] cmd, logic [7:0] wb, logic ack, int stretch_pct);
        tick_t t;
        if (low_run == 0 && $urandom_range(0, 99) < stretch_pct) low_run = $urandom_range(1, 8);
        t.cmd = cmd;
        t.write_byte = wb;
        t.send_ack = ack;
        t.scl_in = (low_run == 0);
        t.sda_in = 1'($urandom_range(0, 1));
        if (low_run > 0) low_run--;
        tick_q.push_back(t);
    endtask

    // one command followed by filler ticks; noise puts random codes in the filler
    task automatic push_cmd(logic [2:0] cmd, logic [7:0] wb, logic ack, int fill,
                            int stretch_pct, bit noise);
        push_tick(cmd, wb, ack, stretch_pct);
        repeat (fill) begin
            push_tick(noise && $urandom_range(0, 9) == 0 ? 3'($urandom_range(0, 7)) : CMD_NONE,
                      8'($urandom), 1'($urandom), stretch_pct);
        end
    endtask

    task automatic drain_all();
        while (tick_q.size() != 0 || s_tvalid || bus_result_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(logic [15:0] half, logic [15:0] tmo, logic en);
        apb_write(REG_HALF, 32'(half));
        apb_write(REG_TIMEOUT, 32'(tmo));
        apb_write(REG_STRETCH, 32'(en));
        cfg_half = half;
        cfg_tmo = tmo;
        cfg_en = en;
    endtask

    initial begin
        int half_of[6] = '{1, 0, 2, 3, 1, 2};
        int tmo_of[6] = '{3, 0, 65535, 1, 2, 5};
        int en_of[6] = '{1, 1, 1, 0, 1, 1};
        int str_of[6] = '{20, 10, 5, 30, 40, 15};
        int count, h;
        logic [2:0] c;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: every command, byte extremes, both acks, unused codes, busy commands
        push_cmd(CMD_START, 8'h00, 1'b0, 20, 0, 0);
        push_cmd(CMD_WRITE, 8'hff, 1'b0, 150, 0, 0);
        push_cmd(CMD_WRITE, 8'h00, 1'b1, 150, 0, 0);
        push_cmd(CMD_WRITE, 8'ha5, 1'b0, 150, 0, 1);
        push_cmd(CMD_READ, 8'h5a, 1'b1, 120, 0, 0);
        push_cmd(CMD_READ, 8'hff, 1'b0, 120, 0, 1);
        push_cmd(CMD_RESTART, 8'h00, 1'b0, 20, 0, 1);
        push_cmd(CMD_STOP, 8'h00, 1'b0, 20, 0, 0);
        push_cmd(3'd6, 8'h00, 1'b0, 2, 0, 0);
        push_cmd(3'd7, 8'h00, 1'b0, 2, 0, 0);
        push_cmd(CMD_NONE, 8'h00, 1'b0, 2, 0, 0);
        // stretched stop under the reset limit
        push_cmd(CMD_STOP, 8'h00, 1'b0, 60, 100, 0);
        drain_all();

        for (int p = 0; p < 6; p++) begin
            set_config(16'(half_of[p]), 16'(tmo_of[p]), 1'(en_of[p]));
            idle_mode = p % 4;
            h = (half_of[p] == 0) ? 1 : half_of[p];
            count = 0;
            while (count < 100) begin
                c = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) :
                    3'($urandom_range(1, 5));
                push_cmd(c, 8'($urandom), 1'($urandom), 0, str_of[p], 1);
                count++;
                for (int k = $urandom_range(0, 35 * h + 10); k > 0; k--) begin
                    push_tick(CMD_NONE, 8'($urandom), 1'($urandom), str_of[p]);
                    count++;
                end
            end
            drain_all();
        end

        // longest hold: one start with stretching off
        idle_mode = MODE_NONE;
        set_config(16'hffff, 16'd1, 1'b0);
        push_cmd(CMD_START, 8'h00, 1'b0, 40, 0, 0);
        drain_all();
        gen_done = 1'b1;
    end

    initial begin
        wait (gen_done);
        repeat (20) @(posedge aclk);
        if (bus_result_q.size() != 0)
            report_mismatch("results left over", 0, bus_result_q.size());
        $display("covered %0d ticks, %0d commands started, %0d stretch timeouts",
                 results_seen, cmds_started, timeouts_seen);
        $display("seven register settings incl. zero and full-scale hold, four idle patterns");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("run timed out");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
